>>> rtl/core/tal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tal_pkg
// Shared types and constants for the binary-lifting ancestor / LCA engine.
// ----------------------------------------------------------------------------
package tal_pkg;

   // Fixed field widths
   localparam int NODE_W   = 10;
   localparam int LEVEL_W  = 10;
   localparam int LEN_W    = 26;
   localparam int WEIGHT_W = 16;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
   localparam logic [LEN_W-1:0]   DIST_MAX  = '1;
   localparam logic [NODE_W-1:0]  ROOT_RESET = NODE_W'(1);

   // Parameter defaults
   localparam int DEF_MAX_NODES   = 1024;
   localparam int DEF_LOG_LEVELS  = 10;
   localparam int DEF_WEIGHT_BITS = 16;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 2'd0,
      OP_KTH  = 2'd1,
      OP_LCA  = 2'd2,
      OP_DIST = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_DEPTH  = 2'd1,
      STATUS_ABSENT = 2'd2
   } status_type;

   // One word of the per-node store
   typedef struct packed {
      logic                present;
      logic [LEVEL_W-1:0]  level;
      logic [LEN_W-1:0]    root_len;
   } node_info_type;

   // Result handed from the sequencer to the output register
   typedef struct packed {
      logic [NODE_W-1:0]   result_node;
      logic [LEN_W-1:0]    path_length;
      logic [LEVEL_W-1:0]  node_level;
      status_type          status;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_ROOT,
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_CHECK,
      ST_ADD_STEP,
      ST_ADD_WAIT,
      ST_ADD_NODE,
      ST_CLIMB,
      ST_CLIMB_WAIT,
      ST_LCA_TEST,
      ST_LCA_CHK,
      ST_LCA_RU,
      ST_LCA_RV,
      ST_LCA_FIN,
      ST_LCA_FIN_WAIT,
      ST_LCA_INFO,
      ST_LCA_INFO_WAIT,
      ST_DONE
   } state_type;

endpackage

>>> rtl/core/tree_ancestor_lca_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_ancestor_lca_engine_top
// Binary-lifting engine over a weighted tree grown parent first: add node,
// k-th ancestor, lowest common ancestor and weighted distance.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+--------------------------------
//   req_     | in        | req_valid/req_stall| operation, node_a, node_b,
//            |           |                    | amount, edge_weight
//   rsp_     | out       | rsp_valid/rsp_stall| result_node, path_length,
//            |           |                    | node_level, status
//   csr_     | in        | csr_valid/csr_ready| root_node
//
// One item at a time: the input is taken again only once the result has moved
// into the output register. Walks are paced by the single read port of the
// jump table (one read per lifting step, two per LCA step).
// Reset or a root write runs a clearing pass over the node store and then
// plants the root; req_stall stays high during it.
// A finished result waits in the output register while rsp_stall is high.
// ----------------------------------------------------------------------------
module tree_ancestor_lca_engine_top #(
   parameter int MAX_NODES   = tal_pkg::DEF_MAX_NODES,
   parameter int LOG_LEVELS  = tal_pkg::DEF_LOG_LEVELS,
   parameter int WEIGHT_BITS = tal_pkg::DEF_WEIGHT_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [tal_pkg::OP_W-1:0]     req_operation,
   input  logic [tal_pkg::NODE_W-1:0]   req_node_a,
   input  logic [tal_pkg::NODE_W-1:0]   req_node_b,
   input  logic [tal_pkg::LEVEL_W-1:0]  req_amount,
   input  logic [tal_pkg::WEIGHT_W-1:0] req_edge_weight,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tal_pkg::NODE_W-1:0]   rsp_result_node,
   output logic [tal_pkg::LEN_W-1:0]    rsp_path_length,
   output logic [tal_pkg::LEVEL_W-1:0]  rsp_node_level,
   output logic [tal_pkg::STATUS_W-1:0] rsp_status,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tal_pkg::NODE_W-1:0]   csr_root_node
);
   import tal_pkg::*;

   logic [NODE_W-1:0] root_ff, root_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           out_ff, out_in;
   logic              busy, res_valid, res_take, cfg_start;
   rsp_type           res;

   assign csr_ready = 1'b1;
   assign cfg_start = csr_valid & csr_ready;
   assign res_take  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = busy;

   tal_seq #(
      .MAX_NODES   (MAX_NODES),
      .LOG_LEVELS  (LOG_LEVELS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .cfg_start       (cfg_start),
      .root_node       (root_ff),
      .req_valid       (req_valid),
      .req_operation   (req_operation),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .req_amount      (req_amount),
      .req_edge_weight (req_edge_weight),
      .busy            (busy),
      .res_valid       (res_valid),
      .res_take        (res_take),
      .res             (res)
   );

   // Root register and output slot
   always_comb begin
      root_in      = cfg_start ? csr_root_node : root_ff;
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         out_in       = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff      <= ROOT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_node = out_ff.result_node;
   assign rsp_path_length = out_ff.path_length;
   assign rsp_node_level  = out_ff.node_level;
   assign rsp_status      = out_ff.status;

endmodule

>>> rtl/core/tal_node_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tal_node_mem
// Per-node store: present flag, depth and distance from the root.
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module tal_node_mem #(
   parameter int MAX_NODES = tal_pkg::DEF_MAX_NODES,
   parameter int AW        = 10
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  tal_pkg::node_info_type wr_data,
   input  logic [AW-1:0]          rd_addr,
   output tal_pkg::node_info_type rd_data
);
   import tal_pkg::*;

   node_info_type mem [0:MAX_NODES-1];
   node_info_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/tal_jump_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tal_jump_mem
// Binary-lifting table: entry {node, j} holds the 2^j-th ancestor of node.
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module tal_jump_mem #(
   parameter int DEPTH = 16384,
   parameter int JAW   = 14
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [JAW-1:0]             wr_addr,
   input  logic [tal_pkg::NODE_W-1:0] wr_data,
   input  logic [JAW-1:0]             rd_addr,
   output logic [tal_pkg::NODE_W-1:0] rd_data
);
   import tal_pkg::*;

   logic [NODE_W-1:0] mem [0:DEPTH-1];
   logic [NODE_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/tal_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tal_seq
// Sequencer: clears the node store, plants the root, and runs add, climb
// and LCA walks one table read at a time through a shared step/compare unit.
// ----------------------------------------------------------------------------
module tal_seq #(
   parameter int MAX_NODES   = tal_pkg::DEF_MAX_NODES,
   parameter int LOG_LEVELS  = tal_pkg::DEF_LOG_LEVELS,
   parameter int WEIGHT_BITS = tal_pkg::DEF_WEIGHT_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cfg_start,
   input  logic [tal_pkg::NODE_W-1:0]   root_node,
   input  logic                         req_valid,
   input  logic [tal_pkg::OP_W-1:0]     req_operation,
   input  logic [tal_pkg::NODE_W-1:0]   req_node_a,
   input  logic [tal_pkg::NODE_W-1:0]   req_node_b,
   input  logic [tal_pkg::LEVEL_W-1:0]  req_amount,
   input  logic [tal_pkg::WEIGHT_W-1:0] req_edge_weight,
   output logic                         busy,
   output logic                         res_valid,
   input  logic                         res_take,
   output tal_pkg::rsp_type             res
);
   import tal_pkg::*;

   localparam int AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int JW   = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
   localparam int JCW  = $clog2(LOG_LEVELS + 1);
   localparam int JAW  = AW + JW;
   localparam int JDEPTH = MAX_NODES << JW;
   localparam int CW   = (LOG_LEVELS > LEVEL_W) ? LOG_LEVELS : LEVEL_W;
   localparam int CLR_N = (MAX_NODES > LOG_LEVELS) ? MAX_NODES : LOG_LEVELS;
   localparam int CLRW = $clog2(CLR_N + 1);
   localparam logic [WEIGHT_W-1:0] W_MASK = (WEIGHT_BITS >= WEIGHT_W) ? '1 :
      WEIGHT_W'((32'd1 << WEIGHT_BITS) - 32'd1);
   localparam logic [JCW-1:0] J_TOP = JCW'(LOG_LEVELS - 1);
   localparam logic [JCW-1:0] J_END = JCW'(LOG_LEVELS);

   state_type            state_ff, state_in;
   logic [CLRW-1:0]      clr_ff, clr_in;
   op_type               op_ff, op_in;
   logic [NODE_W-1:0]    a_ff, a_in, b_ff, b_in;
   logic [LEVEL_W-1:0]   k_ff, k_in;
   logic [WEIGHT_W-1:0]  w_ff, w_in;
   node_info_type        ia_ff, ia_in, ib_ff, ib_in;
   logic [NODE_W-1:0]    u_ff, u_in, v_ff, v_in, n_ff, n_in, pu_ff, pu_in;
   logic [LEVEL_W-1:0]   ck_ff, ck_in, d_ff, d_in, lv_ff, lv_in;
   logic [LEN_W-1:0]     ds_ff, ds_in;
   logic [JCW-1:0]       j_ff, j_in;
   rsp_type              res_ff, res_in;

   // Memory ports
   logic                 nm_we;
   logic [AW-1:0]        nm_waddr, nm_raddr;
   node_info_type        nm_wdata, nm_q;
   logic                 jm_we;
   logic [JAW-1:0]       jm_waddr, jm_raddr;
   logic [NODE_W-1:0]    jm_wdata, jm_q;

   // Shared step / compare unit
   logic [CW-1:0]        step;
   logic                 a_rng, b_rng, root_rng, pres_a, pres_b;
   logic [LEVEL_W:0]     lv_sum;
   logic [LEN_W:0]       ds_sum, p_sum, p_twice, p_diff;

   tal_node_mem #(.MAX_NODES(MAX_NODES), .AW(AW)) u_node_mem (
      .clock   (clock),
      .wr_en   (nm_we),
      .wr_addr (nm_waddr),
      .wr_data (nm_wdata),
      .rd_addr (nm_raddr),
      .rd_data (nm_q)
   );

   tal_jump_mem #(.DEPTH(JDEPTH), .JAW(JAW)) u_jump_mem (
      .clock   (clock),
      .wr_en   (jm_we),
      .wr_addr (jm_waddr),
      .wr_data (jm_wdata),
      .rd_addr (jm_raddr),
      .rd_data (jm_q)
   );

   assign step     = CW'(1) << j_ff;
   assign a_rng    = 32'(a_ff) < 32'(MAX_NODES);
   assign b_rng    = 32'(b_ff) < 32'(MAX_NODES);
   assign root_rng = 32'(root_node) < 32'(MAX_NODES);
   assign pres_a   = a_rng & ia_ff.present;
   assign pres_b   = b_rng & nm_q.present;
   assign lv_sum   = {1'b0, nm_q.level} + (LEVEL_W+1)'(1);
   assign ds_sum   = {1'b0, nm_q.root_len} + (LEN_W+1)'(w_ff);
   assign p_sum    = {1'b0, ia_ff.root_len} + {1'b0, ib_ff.root_len};
   assign p_twice  = {nm_q.root_len, 1'b0};
   assign p_diff   = p_sum - p_twice;

   assign busy      = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      op_ff  <= op_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      k_ff   <= k_in;
      w_ff   <= w_in;
      ia_ff  <= ia_in;
      ib_ff  <= ib_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
      n_ff   <= n_in;
      pu_ff  <= pu_in;
      ck_ff  <= ck_in;
      d_ff   <= d_in;
      lv_ff  <= lv_in;
      ds_ff  <= ds_in;
      j_ff   <= j_in;
      res_ff <= res_in;
   end

   // Next state and datapath control
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      w_in     = w_ff;
      ia_in    = ia_ff;
      ib_in    = ib_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      n_in     = n_ff;
      pu_in    = pu_ff;
      ck_in    = ck_ff;
      d_in     = d_ff;
      lv_in    = lv_ff;
      ds_in    = ds_ff;
      j_in     = j_ff;
      res_in   = res_ff;
      nm_we    = 1'b0;
      nm_waddr = AW'(a_ff);
      nm_wdata = '0;
      nm_raddr = AW'(a_ff);
      jm_we    = 1'b0;
      jm_waddr = {AW'(a_ff), j_ff[JW-1:0]};
      jm_wdata = root_node;
      jm_raddr = {AW'(n_ff), j_ff[JW-1:0]};

      unique case (state_ff)
         // Sweep the node store; plant the root's jump entries alongside
         ST_CLEAR: begin
            if (32'(clr_ff) < 32'(MAX_NODES)) begin
               nm_we    = 1'b1;
               nm_waddr = AW'(clr_ff);
            end
            if (root_rng && (32'(clr_ff) < 32'(LOG_LEVELS))) begin
               jm_we    = 1'b1;
               jm_waddr = {AW'(root_node), JW'(clr_ff)};
            end
            clr_in = clr_ff + CLRW'(1);
            if (32'(clr_ff) == 32'(CLR_N - 1)) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_rng) begin
               nm_we            = 1'b1;
               nm_waddr         = AW'(root_node);
               nm_wdata.present = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = op_type'(req_operation);
               a_in     = req_node_a;
               b_in     = req_node_b;
               k_in     = req_amount;
               w_in     = req_edge_weight & W_MASK;
               state_in = ST_RD_A;
            end
         end
         ST_RD_A: begin
            nm_raddr = AW'(a_ff);
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            nm_raddr = AW'(b_ff);
            ia_in    = nm_q;
            state_in = ST_CHECK;
         end
         // Presence and depth checks, then pick the walk
         ST_CHECK: begin
            ib_in  = nm_q;
            res_in = '{result_node: '0, path_length: '0, node_level: '0,
                       status: STATUS_ABSENT};
            unique case (op_ff)
               OP_ADD: begin
                  if (!a_rng || !pres_b) begin
                     state_in = ST_DONE;
                  end else begin
                     lv_in    = lv_sum[LEVEL_W] ? LEVEL_MAX : lv_sum[LEVEL_W-1:0];
                     ds_in    = ds_sum[LEN_W] ? DIST_MAX : ds_sum[LEN_W-1:0];
                     jm_we    = 1'b1;
                     jm_waddr = {AW'(a_ff), JW'(0)};
                     jm_wdata = b_ff;
                     n_in     = b_ff;
                     j_in     = JCW'(1);
                     state_in = ST_ADD_STEP;
                  end
               end
               OP_KTH: begin
                  if (!pres_a) begin
                     state_in = ST_DONE;
                  end else if (k_ff > ia_ff.level) begin
                     res_in.status = STATUS_DEPTH;
                     state_in      = ST_DONE;
                  end else begin
                     n_in     = a_ff;
                     ck_in    = k_ff;
                     lv_in    = ia_ff.level - k_ff;
                     j_in     = J_TOP;
                     state_in = ST_CLIMB;
                  end
               end
               default: begin
                  if (!pres_a || !pres_b) begin
                     state_in = ST_DONE;
                  end else begin
                     if (ia_ff.level > nm_q.level) begin
                        u_in  = b_ff;
                        n_in  = a_ff;
                        ck_in = ia_ff.level - nm_q.level;
                        d_in  = nm_q.level;
                     end else begin
                        u_in  = a_ff;
                        n_in  = b_ff;
                        ck_in = nm_q.level - ia_ff.level;
                        d_in  = ia_ff.level;
                     end
                     j_in     = J_TOP;
                     state_in = ST_CLIMB;
                  end
               end
            endcase
         end
         // Build ancestors of the new node: entry j from entry j-1, or the root past its depth
         ST_ADD_STEP: begin
            if (j_ff >= J_END) begin
               state_in = ST_ADD_NODE;
            end else if (step <= CW'(lv_ff)) begin
               jm_raddr = {AW'(n_ff), JW'(j_ff - JCW'(1))};
               state_in = ST_ADD_WAIT;
            end else begin
               jm_we    = 1'b1;
               jm_wdata = root_node;
               j_in     = j_ff + JCW'(1);
            end
         end
         ST_ADD_WAIT: begin
            jm_we    = 1'b1;
            jm_wdata = jm_q;
            n_in     = jm_q;
            j_in     = j_ff + JCW'(1);
            state_in = ST_ADD_STEP;
         end
         ST_ADD_NODE: begin
            nm_we    = 1'b1;
            nm_waddr = AW'(a_ff);
            nm_wdata = '{present: 1'b1, level: lv_ff, root_len: ds_ff};
            res_in   = '{result_node: a_ff, path_length: '0, node_level: lv_ff,
                         status: STATUS_OK};
            state_in = ST_DONE;
         end
         // Climb ck levels, largest jumps first
         ST_CLIMB: begin
            if (ck_ff == '0) begin
               if (op_ff == OP_KTH) begin
                  res_in   = '{result_node: n_ff, path_length: '0, node_level: lv_ff,
                               status: STATUS_OK};
                  state_in = ST_DONE;
               end else begin
                  v_in     = n_ff;
                  state_in = ST_LCA_TEST;
               end
            end else if (CW'(ck_ff) >= step) begin
               jm_raddr = {AW'(n_ff), j_ff[JW-1:0]};
               state_in = ST_CLIMB_WAIT;
            end else begin
               j_in = j_ff - JCW'(1);
            end
         end
         ST_CLIMB_WAIT: begin
            n_in     = jm_q;
            ck_in    = ck_ff - LEVEL_W'(step);
            state_in = ST_CLIMB;
         end
         ST_LCA_TEST: begin
            if (u_ff == v_ff) begin
               n_in     = u_ff;
               state_in = ST_LCA_INFO;
            end else begin
               j_in     = J_TOP;
               state_in = ST_LCA_CHK;
            end
         end
         // Lift both nodes while their 2^j ancestors differ
         ST_LCA_CHK: begin
            if (step <= CW'(d_ff)) begin
               jm_raddr = {AW'(u_ff), j_ff[JW-1:0]};
               state_in = ST_LCA_RU;
            end else if (j_ff == '0) begin
               state_in = ST_LCA_FIN;
            end else begin
               j_in = j_ff - JCW'(1);
            end
         end
         ST_LCA_RU: begin
            pu_in    = jm_q;
            jm_raddr = {AW'(v_ff), j_ff[JW-1:0]};
            state_in = ST_LCA_RV;
         end
         ST_LCA_RV: begin
            state_in = ST_LCA_CHK;
            if (pu_ff != jm_q) begin
               u_in = pu_ff;
               v_in = jm_q;
               d_in = d_ff - LEVEL_W'(step);
            end else if (j_ff == '0) begin
               state_in = ST_LCA_FIN;
            end else begin
               j_in = j_ff - JCW'(1);
            end
         end
         ST_LCA_FIN: begin
            jm_raddr = {AW'(u_ff), JW'(0)};
            state_in = ST_LCA_FIN_WAIT;
         end
         ST_LCA_FIN_WAIT: begin
            n_in     = jm_q;
            state_in = ST_LCA_INFO;
         end
         ST_LCA_INFO: begin
            nm_raddr = AW'(n_ff);
            state_in = ST_LCA_INFO_WAIT;
         end
         // Depth of the ancestor; path length for distance queries
         ST_LCA_INFO_WAIT: begin
            res_in = '{result_node: n_ff, path_length: '0, node_level: nm_q.level,
                       status: STATUS_OK};
            if (op_ff == OP_DIST && p_sum > p_twice) begin
               res_in.path_length = p_diff[LEN_W] ? DIST_MAX : p_diff[LEN_W-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase

      // Root rewrite restarts the tree
      if (cfg_start) begin
         state_in = ST_CLEAR;
         clr_in   = '0;
      end
   end

endmodule

>>> test/tree_ancestor_lca_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_ancestor_lca_engine_top_tb
// Drives node adds, k-th ancestor, LCA and distance queries into the engine.
// An in-bench copy of the tree (depths, root distances, ancestor table)
// predicts every result in order. Sender and receiver idle at random, the
// receiver also holds off for a long stretch, and the root register is
// rewritten between phases, including the lowest and highest index.
// ----------------------------------------------------------------------------
module tree_ancestor_lca_engine_top_tb;
   import tal_pkg::*;

   localparam int NODES       = DEF_MAX_NODES;
   localparam int LEVELS      = DEF_LOG_LEVELS;
   localparam int SETTLE      = 5 * DEF_LOG_LEVELS + 20;
   localparam int CYCLE_LIMIT = 2000000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [OP_W-1:0]      req_operation;
   logic [NODE_W-1:0]    req_node_a;
   logic [NODE_W-1:0]    req_node_b;
   logic [LEVEL_W-1:0]   req_amount;
   logic [WEIGHT_W-1:0]  req_edge_weight;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [NODE_W-1:0]    rsp_result_node;
   logic [LEN_W-1:0]     rsp_path_length;
   logic [LEVEL_W-1:0]   rsp_node_level;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [NODE_W-1:0]    csr_root_node;

   // Shadow tree
   logic [NODE_W-1:0]    anc [NODES][LEVELS];
   int unsigned          depth_of [NODES];
   longint unsigned      root_len_of [NODES];
   bit                   present_of [NODES];
   logic [NODE_W-1:0]    root_q;
   int                   present_list [$];
   int                   last_added;

   rsp_type              pending_rsp [$];
   int                   error_count;
   int                   tx_idle_pct;
   int                   rx_idle_pct;
   int                   rx_hold;
   longint               cycle_count;

   tree_ancestor_lca_engine_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .req_amount      (req_amount),
      .req_edge_weight (req_edge_weight),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_node (rsp_result_node),
      .rsp_path_length (rsp_path_length),
      .rsp_node_level  (rsp_node_level),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_root_node   (csr_root_node)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tree_ancestor_lca_engine_top_tb: errors");
         $finish;
      end
   end

   // Receiver: long hold-off first, else random stall
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rx_hold = rx_hold - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // ---------------- shadow tree ----------------
   function automatic void plant_root(input logic [NODE_W-1:0] r);
      root_q = r;
      foreach (present_of[i]) present_of[i] = 1'b0;
      present_of[r]   = 1'b1;
      depth_of[r]     = 0;
      root_len_of[r]  = 0;
      for (int j = 0; j < LEVELS; j++) anc[r][j] = r;
      present_list = {};
      present_list.insert(present_list.size(), r);
      last_added = r;
   endfunction

   function automatic int lift(input int n, input int k);
      for (int j = LEVELS - 1; j >= 0; j--) begin
         while (k >= (1 << j)) begin
            n = anc[n][j];
            k -= (1 << j);
         end
      end
      return n;
   endfunction

   function automatic int meet_point(input int u, input int v);
      int t;
      int d;
      if (depth_of[u] > depth_of[v]) begin
         t = u; u = v; v = t;
      end
      v = lift(v, depth_of[v] - depth_of[u]);
      if (u == v) return u;
      d = depth_of[u];
      for (int j = LEVELS - 1; j >= 0; j--) begin
         while ((1 << j) <= d && anc[u][j] != anc[v][j]) begin
            u = anc[u][j];
            v = anc[v][j];
            d -= (1 << j);
         end
      end
      return anc[u][0];
   endfunction

   function automatic rsp_type apply_request(input op_type op, input int a, input int b,
                                             input int k, input int w);
      rsp_type         r;
      int unsigned     lv;
      longint unsigned ds;
      longint unsigned sum;
      longint unsigned twice;
      int              m;
      // Keep only the bits that reach the ports
      a = a & ((1 << NODE_W) - 1);
      b = b & ((1 << NODE_W) - 1);
      k = k & ((1 << LEVEL_W) - 1);
      w = w & ((1 << WEIGHT_W) - 1);
      r = '0;
      r.status = STATUS_OK;
      case (op)
         OP_ADD: begin
            if (!present_of[b]) begin
               r.status = STATUS_ABSENT;
            end else begin
               lv = depth_of[b] + 1;
               if (lv > LEVEL_MAX) lv = LEVEL_MAX;
               ds = root_len_of[b] + w;
               if (ds > DIST_MAX) ds = DIST_MAX;
               anc[a][0] = NODE_W'(b);
               for (int j = 1; j < LEVELS; j++)
                  anc[a][j] = ((1 << j) <= lv) ? anc[anc[a][j-1]][j-1] : root_q;
               depth_of[a]    = lv;
               root_len_of[a] = ds;
               if (!present_of[a]) present_list.insert(present_list.size(), a);
               present_of[a] = 1'b1;
               last_added    = a;
               r.result_node = NODE_W'(a);
               r.node_level  = LEVEL_W'(lv);
            end
         end
         OP_KTH: begin
            if (!present_of[a]) r.status = STATUS_ABSENT;
            else if (k > depth_of[a]) r.status = STATUS_DEPTH;
            else begin
               r.result_node = NODE_W'(lift(a, k));
               r.node_level  = LEVEL_W'(depth_of[a] - k);
            end
         end
         default: begin
            if (!present_of[a] || !present_of[b]) begin
               r.status = STATUS_ABSENT;
            end else begin
               m = meet_point(a, b);
               r.result_node = NODE_W'(m);
               r.node_level  = LEVEL_W'(depth_of[m]);
               if (op == OP_DIST) begin
                  sum   = root_len_of[a] + root_len_of[b];
                  twice = 2 * root_len_of[m];
                  sum   = (sum > twice) ? sum - twice : 0;
                  r.path_length = (sum > DIST_MAX) ? DIST_MAX : LEN_W'(sum);
               end
            end
         end
      endcase
      return r;
   endfunction

   // ---------------- drivers ----------------
   task automatic send_request(input op_type op, input int a, input int b,
                               input int k, input int w);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_operation   = op;
      req_node_a      = NODE_W'(a);
      req_node_b      = NODE_W'(b);
      req_amount      = LEVEL_W'(k);
      req_edge_weight = WEIGHT_W'(w);
      do @(posedge clock); while (req_stall);
      pending_rsp.insert(pending_rsp.size(), apply_request(op, a, b, k, w));
   endtask

   task automatic drain_results;
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_root(input int r);
      drain_results();
      @(negedge clock);
      csr_valid     = 1'b1;
      csr_root_node = NODE_W'(r);
      do @(posedge clock); while (!csr_ready);
      plant_root(NODE_W'(r));
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // ---------------- checking ----------------
   task automatic report_mismatch(input string field, input longint want, input longint got);
      $display("mismatch %s: expected %0d got %0d at cycle %0d", field, want, got, cycle_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected transfer", 0, 1);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_result_node !== want.result_node)
               report_mismatch("result_node", want.result_node, rsp_result_node);
            if (rsp_path_length !== want.path_length)
               report_mismatch("path_length", want.path_length, rsp_path_length);
            if (rsp_node_level !== want.node_level)
               report_mismatch("node_level", want.node_level, rsp_node_level);
            if (rsp_status !== want.status)
               report_mismatch("status", want.status, rsp_status);
         end
      end
   end

   // ---------------- tests ----------------
   task automatic test_directed;
      // root 1 after reset
      send_request(OP_KTH, 1, 0, 0, 0);
      send_request(OP_KTH, 1, 0, 1, 0);          // climb past the root
      send_request(OP_LCA, 1, 1, 0, 0);
      send_request(OP_DIST, 0, 1, 0, 0);         // absent node
      send_request(OP_KTH, 1023, 0, 0, 0);
      send_request(OP_ADD, 1023, 1, 0, 16'hFFFF);
      send_request(OP_ADD, 0, 1023, 0, 0);
      send_request(OP_ADD, 5, 7, 0, 3);          // absent parent
      send_request(OP_ADD, 2, 0, 0, 1234);
      send_request(OP_ADD, 3, 1, 1023, 16'h5555);
      send_request(OP_KTH, 2, 0, 3, 0);
      send_request(OP_KTH, 2, 0, 4, 0);
      send_request(OP_KTH, 2, 0, 1023, 0);
      send_request(OP_LCA, 2, 1023, 0, 0);
      send_request(OP_DIST, 2, 3, 0, 0);
      send_request(OP_DIST, 2, 2, 0, 0);
      send_request(OP_LCA, 3, 0, 0, 0);
      send_request(OP_ADD, 2, 3, 0, 16'hAAAA);   // overwrite with new parent
      send_request(OP_DIST, 2, 1023, 0, 0);
      write_root(1023);
      send_request(OP_KTH, 1023, 0, 0, 0);
      send_request(OP_LCA, 2, 1023, 0, 0);       // old node gone
      send_request(OP_ADD, 0, 1023, 0, 16'hFFFF);
      send_request(OP_DIST, 0, 1023, 0, 0);
   endtask

   // Chain through every index: depth saturation and distance saturation
   task automatic test_deep_chain;
      write_root(0);
      for (int n = 1; n < NODES; n++) send_request(OP_ADD, n, n - 1, 0, 16'hFFFF);
      send_request(OP_ADD, 1, 1023, 0, 16'hFFFF);
      send_request(OP_ADD, 2, 1, 0, 16'hFFFF);
      send_request(OP_ADD, 3, 2, 0, 16'hFFFF);
      send_request(OP_KTH, 1023, 0, 1023, 0);
      send_request(OP_KTH, 1000, 0, 777, 0);
      send_request(OP_LCA, 1023, 600, 0, 0);
      send_request(OP_DIST, 3, 0, 0, 0);
      send_request(OP_DIST, 1023, 3, 0, 0);
   endtask

   task automatic random_item;
      int a;
      int b;
      int pick;
      pick = $urandom_range(99);
      if (pick < 12) begin
         send_request(op_type'($urandom_range(3)), $urandom_range(1023), $urandom_range(1023),
                      $urandom_range(1023), $urandom_range(16'hFFFF));
      end else if (pick < 50) begin
         b = ($urandom_range(1)) ? last_added
                                 : present_list[$urandom_range(present_list.size() - 1)];
         a = $urandom_range(1023);
         for (int t = 0; t < 8 && present_of[a]; t++) a = $urandom_range(1023);
         send_request(OP_ADD, a, b, 0, $urandom_range(16'hFFFF));
      end else begin
         a = present_list[$urandom_range(present_list.size() - 1)];
         b = present_list[$urandom_range(present_list.size() - 1)];
         if (pick < 70)
            send_request(OP_KTH, a, b, $urandom_range(depth_of[a] + 2), 0);
         else
            send_request(($urandom_range(1)) ? OP_LCA : OP_DIST, a, b, 0, 0);
      end
   endtask

   task automatic test_random(input int tx_pct, input int rx_pct, input int count);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      write_root($urandom_range(1023));
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) drain_results();
         random_item();
      end
   endtask

   // Receiver stops for a long stretch while items keep coming
   task automatic test_backpressure;
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      rx_hold = 1500;
      for (int i = 0; i < 40; i++) random_item();
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = OP_ADD;
      req_node_a      = '0;
      req_node_b      = '0;
      req_amount      = '0;
      req_edge_weight = '0;
      csr_valid       = 1'b0;
      csr_root_node   = '0;
      rsp_stall       = 1'b0;
      rx_hold         = 0;
      tx_idle_pct     = 34;
      rx_idle_pct     = 63;
      error_count     = 0;
      cycle_count     = 0;
      plant_root(ROOT_RESET);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_deep_chain();
      test_random(34, 63, 250);
      test_random(63, 34, 250);
      test_random(0, 0, 200);
      test_backpressure();

      drain_results();
      if (error_count == 0)
         $display("tree_ancestor_lca_engine_top_tb: clean");
      else
         $display("tree_ancestor_lca_engine_top_tb: errors");
      $finish;
   end

endmodule
